// ----- hw/rtl/pscs_pkg.sv -----
package pscs_pkg;

   localparam int unsigned PAIR_COUNT  = 3;
   localparam int unsigned SLOPE_COUNT = 2;
   localparam int unsigned ANGLE_W     = 15;
   localparam int unsigned CERT_W      = 16;
   localparam int unsigned MATRIX_W    = PAIR_COUNT * PAIR_COUNT;
   localparam int unsigned DIFF_W      = 12;
   localparam int unsigned NUM_W       = 21;
   localparam int unsigned RECIP_W     = 22;
   localparam int unsigned RECIP_SHIFT = 27;
   localparam int unsigned PROD_W      = NUM_W + RECIP_W;
   localparam int unsigned SCALE_W     = 31;
   localparam int unsigned LATENCY     = 4;

   // 10 and 45 degrees in 1/64 degree
   localparam logic [ANGLE_W-1:0] DEAD_ZONE = 15'd640;
   localparam logic [ANGLE_W-1:0] CUT_ANGLE = 15'd2880;
   localparam logic [CERT_W-1:0]  CERT_ONE  = 16'd32768;

   // (d*32768 + 1120) / 2240 == (d*512 + 17) / 35
   localparam logic [NUM_W-1:0]   LIN_BIAS  = 21'd17;
   localparam int unsigned        LIN_SHIFT = 9;
   // ceil(2^27 / 35), exact for numerators below 2^21
   localparam logic [RECIP_W-1:0] RECIP_MUL = 22'd3834793;

   localparam logic [SCALE_W-1:0] ROUND_HALF = 31'd16384;
   localparam int unsigned        SCALE_SHIFT = 15;

   typedef struct packed {
      logic               neg;
      logic [SCALE_W-1:0] prod;
   } lane_out_type;

endpackage

// ----- hw/rtl/pdoa_slope_certitude_select_top.sv -----
// pdoa slope certitude selection
// request channel: start with req_pd_angle_* and req_raw_cert_* (one measurement
//   set per transaction), taken at a clock edge where start is high and busy low
// busy stays low: a new transaction is taken every cycle
// response channel: rsp_valid is high for exactly one cycle with the six
//   rsp_falling_cert_* / rsp_rising_cert_* values; the receiver cannot stall it
// pipeline: the response follows the accepting edge through one register stage
//   each for magnitude/range, reciprocal divide by 35, raw certitude scaling,
//   and rounding with per-slot max
// throughput: one transaction per cycle, responses in request order
// csr channel: csr_valid/csr_ready write of the 9-bit swap matrix; csr_ready
//   is always high; write only while no transaction is in flight
// reset: synchronous, active high; clears the pipeline valid bits and the
//   swap matrix to zero
module pdoa_slope_certitude_select_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [pscs_pkg::ANGLE_W-1:0]  req_pd_angle_0,
   input  logic signed [pscs_pkg::ANGLE_W-1:0]  req_pd_angle_1,
   input  logic signed [pscs_pkg::ANGLE_W-1:0]  req_pd_angle_2,
   input  logic        [pscs_pkg::CERT_W-1:0]   req_raw_cert_0,
   input  logic        [pscs_pkg::CERT_W-1:0]   req_raw_cert_1,
   input  logic        [pscs_pkg::CERT_W-1:0]   req_raw_cert_2,
   output logic                                 rsp_valid,
   output logic        [pscs_pkg::CERT_W-1:0]   rsp_falling_cert_0,
   output logic        [pscs_pkg::CERT_W-1:0]   rsp_falling_cert_1,
   output logic        [pscs_pkg::CERT_W-1:0]   rsp_falling_cert_2,
   output logic        [pscs_pkg::CERT_W-1:0]   rsp_rising_cert_0,
   output logic        [pscs_pkg::CERT_W-1:0]   rsp_rising_cert_1,
   output logic        [pscs_pkg::CERT_W-1:0]   rsp_rising_cert_2,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [pscs_pkg::MATRIX_W-1:0] csr_slope_swap_matrix
);

   logic signed [pscs_pkg::ANGLE_W-1:0] angle [pscs_pkg::PAIR_COUNT];
   logic        [pscs_pkg::CERT_W-1:0]  raw [pscs_pkg::PAIR_COUNT];
   pscs_pkg::lane_out_type              lane_out [pscs_pkg::PAIR_COUNT];
   logic        [pscs_pkg::CERT_W-1:0]  falling [pscs_pkg::PAIR_COUNT];
   logic        [pscs_pkg::CERT_W-1:0]  rising [pscs_pkg::PAIR_COUNT];

   logic [pscs_pkg::MATRIX_W-1:0] matrix_ff;
   logic [pscs_pkg::MATRIX_W-1:0] matrix_in;
   logic [pscs_pkg::LATENCY-1:0]  vld_ff;
   logic [pscs_pkg::LATENCY-1:0]  vld_in;
   logic                          accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   assign matrix_in = (csr_valid & csr_ready) ? csr_slope_swap_matrix : matrix_ff;
   assign vld_in    = {vld_ff[pscs_pkg::LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= '0;
         vld_ff    <= '0;
      end else begin
         matrix_ff <= matrix_in;
         vld_ff    <= vld_in;
      end
   end

   assign angle[0] = req_pd_angle_0;
   assign angle[1] = req_pd_angle_1;
   assign angle[2] = req_pd_angle_2;
   assign raw[0]   = req_raw_cert_0;
   assign raw[1]   = req_raw_cert_1;
   assign raw[2]   = req_raw_cert_2;

   for (genvar i = 0; i < pscs_pkg::PAIR_COUNT; i++) begin : g_lane
      pscs_cert_lane u_lane (
         .clock    (clock),
         .angle    (angle[i]),
         .raw_cert (raw[i]),
         .lane_out (lane_out[i])
      );
   end

   pscs_slot_max u_slot_max (
      .clock        (clock),
      .lane_out     (lane_out),
      .swap_matrix  (matrix_ff),
      .falling_cert (falling),
      .rising_cert  (rising)
   );

   assign rsp_valid          = vld_ff[pscs_pkg::LATENCY-1];
   assign rsp_falling_cert_0 = falling[0];
   assign rsp_falling_cert_1 = falling[1];
   assign rsp_falling_cert_2 = falling[2];
   assign rsp_rising_cert_0  = rising[0];
   assign rsp_rising_cert_1  = rising[1];
   assign rsp_rising_cert_2  = rising[2];

endmodule

// ----- hw/rtl/pscs_cert_lane.sv -----
module pscs_cert_lane (
   input  logic                                  clock,
   input  logic signed [pscs_pkg::ANGLE_W-1:0]   angle,
   input  logic        [pscs_pkg::CERT_W-1:0]    raw_cert,
   output pscs_pkg::lane_out_type                lane_out
);

   logic [pscs_pkg::ANGLE_W-1:0] angle_u;
   logic [pscs_pkg::ANGLE_W-1:0] mag;
   logic [pscs_pkg::ANGLE_W-1:0] diff;
   logic [pscs_pkg::NUM_W-1:0]   num;
   logic [pscs_pkg::CERT_W-1:0]  raw_sat;

   logic                         a_neg_ff;
   logic                         a_hi_ff;
   logic                         a_lo_ff;
   logic [pscs_pkg::NUM_W-1:0]   a_num_ff;
   logic [pscs_pkg::CERT_W-1:0]  a_raw_ff;

   logic [pscs_pkg::PROD_W-1:0]  quot_prod;
   logic [pscs_pkg::CERT_W-1:0]  cert_in;

   logic                         b_neg_ff;
   logic [pscs_pkg::CERT_W-1:0]  b_cert_ff;
   logic [pscs_pkg::CERT_W-1:0]  b_raw_ff;

   logic [2*pscs_pkg::CERT_W-1:0] scale_prod;
   logic                          c_neg_ff;
   logic [pscs_pkg::SCALE_W-1:0]  c_prod_ff;

   // stage a: magnitude, range and linear numerator
   assign angle_u = angle;
   assign mag     = angle_u[pscs_pkg::ANGLE_W-1] ? (~angle_u + 15'd1) : angle_u;
   assign diff    = mag - pscs_pkg::DEAD_ZONE;
   assign num     = {diff[pscs_pkg::DIFF_W-1:0], {pscs_pkg::LIN_SHIFT{1'b0}}}
                    + pscs_pkg::LIN_BIAS;
   assign raw_sat = (raw_cert > pscs_pkg::CERT_ONE) ? pscs_pkg::CERT_ONE : raw_cert;

   always_ff @(posedge clock) begin
      a_neg_ff <= angle_u[pscs_pkg::ANGLE_W-1];
      a_hi_ff  <= mag > pscs_pkg::CUT_ANGLE;
      a_lo_ff  <= mag < pscs_pkg::DEAD_ZONE;
      a_num_ff <= num;
      a_raw_ff <= raw_sat;
   end

   // stage b: divide by 35 through reciprocal multiply
   assign quot_prod = {{pscs_pkg::RECIP_W{1'b0}}, a_num_ff} * pscs_pkg::PROD_W'(pscs_pkg::RECIP_MUL);

   always_comb begin
      priority if (a_hi_ff) begin
         cert_in = pscs_pkg::CERT_ONE;
      end else if (a_lo_ff) begin
         cert_in = '0;
      end else begin
         cert_in = quot_prod[pscs_pkg::RECIP_SHIFT +: pscs_pkg::CERT_W];
      end
   end

   always_ff @(posedge clock) begin
      b_neg_ff  <= a_neg_ff;
      b_cert_ff <= cert_in;
      b_raw_ff  <= a_raw_ff;
   end

   // stage c: scale by raw certitude
   assign scale_prod = b_cert_ff * b_raw_ff;

   always_ff @(posedge clock) begin
      c_neg_ff  <= b_neg_ff;
      c_prod_ff <= scale_prod[pscs_pkg::SCALE_W-1:0];
   end

   assign lane_out.neg  = c_neg_ff;
   assign lane_out.prod = c_prod_ff;

endmodule

// ----- hw/rtl/pscs_slot_max.sv -----
module pscs_slot_max (
   input  logic                                 clock,
   input  pscs_pkg::lane_out_type               lane_out [pscs_pkg::PAIR_COUNT],
   input  logic [pscs_pkg::MATRIX_W-1:0]        swap_matrix,
   output logic [pscs_pkg::CERT_W-1:0]          falling_cert [pscs_pkg::PAIR_COUNT],
   output logic [pscs_pkg::CERT_W-1:0]          rising_cert [pscs_pkg::PAIR_COUNT]
);

   logic [pscs_pkg::SCALE_W-1:0] rounded [pscs_pkg::PAIR_COUNT];
   logic [pscs_pkg::CERT_W-1:0]  scaled [pscs_pkg::PAIR_COUNT];
   logic [pscs_pkg::CERT_W-1:0]  fall_in [pscs_pkg::PAIR_COUNT];
   logic [pscs_pkg::CERT_W-1:0]  rise_in [pscs_pkg::PAIR_COUNT];
   logic [pscs_pkg::CERT_W-1:0]  fall_ff [pscs_pkg::PAIR_COUNT];
   logic [pscs_pkg::CERT_W-1:0]  rise_ff [pscs_pkg::PAIR_COUNT];

   for (genvar i = 0; i < pscs_pkg::PAIR_COUNT; i++) begin : g_round
      assign rounded[i] = lane_out[i].prod + pscs_pkg::ROUND_HALF;
      assign scaled[i]  = rounded[i][pscs_pkg::SCALE_SHIFT +: pscs_pkg::CERT_W];
   end

   for (genvar p = 0; p < pscs_pkg::PAIR_COUNT; p++) begin : g_pair
      localparam int unsigned OA = (p + 1) % pscs_pkg::PAIR_COUNT;
      localparam int unsigned OB = (p + 2) % pscs_pkg::PAIR_COUNT;

      logic                        rise_a;
      logic                        rise_b;
      logic [pscs_pkg::CERT_W-1:0] fall_a;
      logic [pscs_pkg::CERT_W-1:0] fall_b;
      logic [pscs_pkg::CERT_W-1:0] ris_a;
      logic [pscs_pkg::CERT_W-1:0] ris_b;

      assign rise_a = lane_out[OA].neg ^ swap_matrix[p*pscs_pkg::PAIR_COUNT + OA];
      assign rise_b = lane_out[OB].neg ^ swap_matrix[p*pscs_pkg::PAIR_COUNT + OB];
      assign fall_a = rise_a ? '0 : scaled[OA];
      assign fall_b = rise_b ? '0 : scaled[OB];
      assign ris_a  = rise_a ? scaled[OA] : '0;
      assign ris_b  = rise_b ? scaled[OB] : '0;

      assign fall_in[p] = (fall_a > fall_b) ? fall_a : fall_b;
      assign rise_in[p] = (ris_a > ris_b) ? ris_a : ris_b;

      always_ff @(posedge clock) begin
         fall_ff[p] <= fall_in[p];
         rise_ff[p] <= rise_in[p];
      end

      assign falling_cert[p] = fall_ff[p];
      assign rising_cert[p]  = rise_ff[p];
   end

endmodule
